[design/overlay_memory_map_decoder_core_defines.svh]
// Assertion macros used by the decoder back end (omdec_back).
// They expect the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef OVERLAY_MEMORY_MAP_DECODER_CORE_DEFINES_SVH
`define OVERLAY_MEMORY_MAP_DECODER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OMD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/omdec_pkg.sv]
package omdec_pkg;

    localparam int RAM_BYTES_DEF = 131072;
    localparam int ROM_BYTES_DEF = 65536;

    // Widest store index over the legal store sizes.
    localparam int IDX_W  = 22;
    localparam int LANES  = 4;
    localparam int QDEPTH = 2;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    localparam logic [3:0] REGION_LOW_0    = 4'h0;
    localparam logic [3:0] REGION_LOW_1    = 4'h1;
    localparam logic [3:0] REGION_LOW_2    = 4'h2;
    localparam logic [3:0] REGION_LOW_3    = 4'h3;
    localparam logic [3:0] REGION_ROM      = 4'h4;
    localparam logic [3:0] REGION_MIRROR_A = 4'h6;
    localparam logic [3:0] REGION_MIRROR_B = 4'h7;
    localparam logic [3:0] REGION_IWM      = 4'hd;
    localparam logic [3:0] REGION_DEV      = 4'he;

    localparam logic [23:0] ROM_BASE    = 24'h400000;
    localparam logic [23:0] MIRROR_BASE = 24'h600000;
    localparam int          VIA_SEL_BIT = 19;
    localparam logic [7:0]  IWM_BYTE    = 8'h1f;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_RAM  = 2'd1,
        TGT_ROM  = 2'd2
    } t_target;

    // One byte lane after decode.
    typedef struct packed {
        t_target          tgt;
        logic             wr;
        logic [IDX_W-1:0] idx;
        logic [7:0]       wbyte;
        logic [7:0]       rconst;
        logic             dev;
        logic             flt;
    } t_lane_op;

    // One decoded word, lane 0 is the last byte.
    typedef struct packed {
        t_lane_op [LANES-1:0] lanes;
        logic                 normal_map;
    } t_op;

endpackage

[design/omdec_front.sv]
module omdec_front #(
    parameter int RAM_BYTES = omdec_pkg::RAM_BYTES_DEF,
    parameter int ROM_BYTES = omdec_pkg::ROM_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_q_full,
    input  logic [1:0]       i_mode,
    input  logic [1:0]       i_access_size,
    input  logic [23:0]      i_address,
    input  logic [31:0]      i_write_data,
    input  logic             i_overlay,
    output logic             o_q_push,
    output omdec_pkg::t_op   o_q_data
);

    localparam logic [23:0] RAM_MASK = 24'(RAM_BYTES - 1);
    localparam logic [23:0] ROM_MASK = 24'(ROM_BYTES - 1);

    logic        r_pending;
    logic        r_switched;
    logic        n_pending;
    logic        n_switched;
    logic        accept;
    logic        is_read;
    logic        is_rw;
    logic [1:0]  last_lane;
    logic        touch;
    logic [23:0] lane_addr [omdec_pkg::LANES];
    logic        lane_valid [omdec_pkg::LANES];

    function automatic omdec_pkg::t_lane_op classify(
        input logic [23:0] a,
        input logic        rd,
        input logic [7:0]  wb,
        input logic        ovl
    );
        omdec_pkg::t_lane_op op;
        logic [23:0]         off_rom;
        logic [23:0]         off_ram;
        op.tgt    = omdec_pkg::TGT_NONE;
        op.wr     = !rd;
        op.idx    = '0;
        op.wbyte  = wb;
        op.rconst = '0;
        op.dev    = 1'b0;
        op.flt    = 1'b0;
        off_rom   = (a - omdec_pkg::ROM_BASE) & ROM_MASK;
        off_ram   = (a - omdec_pkg::MIRROR_BASE) & RAM_MASK;
        case (a[23:20])
            omdec_pkg::REGION_LOW_0, omdec_pkg::REGION_LOW_1,
            omdec_pkg::REGION_LOW_2, omdec_pkg::REGION_LOW_3: begin
                if (rd && ovl) begin
                    op.tgt = omdec_pkg::TGT_ROM;
                    op.idx = omdec_pkg::IDX_W'(a & ROM_MASK);
                end else if (!ovl) begin
                    op.tgt = omdec_pkg::TGT_RAM;
                    op.idx = omdec_pkg::IDX_W'(a & RAM_MASK);
                end
            end
            omdec_pkg::REGION_ROM: begin
                if (rd) begin
                    op.tgt = omdec_pkg::TGT_ROM;
                    op.idx = omdec_pkg::IDX_W'(off_rom);
                end
            end
            omdec_pkg::REGION_MIRROR_A, omdec_pkg::REGION_MIRROR_B: begin
                if (ovl) begin
                    op.tgt = omdec_pkg::TGT_RAM;
                    op.idx = omdec_pkg::IDX_W'(off_ram);
                end
            end
            omdec_pkg::REGION_IWM: begin
                op.flt = 1'b1;
                if (rd) begin
                    op.rconst = omdec_pkg::IWM_BYTE;
                end
            end
            omdec_pkg::REGION_DEV: begin
                if (a[omdec_pkg::VIA_SEL_BIT]) begin
                    op.dev = 1'b1;
                end else begin
                    op.flt = 1'b1;
                end
            end
            default: begin
                op.flt = 1'b1;
            end
        endcase
        return op;
    endfunction

    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;
    assign is_read  = (i_mode == omdec_pkg::MODE_READ);
    assign is_rw    = is_read || (i_mode == omdec_pkg::MODE_WRITE);

    always_comb begin
        case (i_access_size)
            omdec_pkg::SIZE_BYTE: last_lane = 2'd0;
            omdec_pkg::SIZE_WORD: last_lane = 2'd1;
            default:              last_lane = 2'd3;
        endcase
    end

    // The first byte of the access lands in the highest lane in use.
    always_comb begin
        touch = 1'b0;
        for (int j = 0; j < omdec_pkg::LANES; j++) begin
            lane_valid[j] = (2'(j) <= last_lane);
            lane_addr[j]  = i_address + {22'b0, 2'(last_lane - 2'(j))};
            o_q_data.lanes[j].tgt    = omdec_pkg::TGT_NONE;
            o_q_data.lanes[j].wr     = 1'b0;
            o_q_data.lanes[j].idx    = '0;
            o_q_data.lanes[j].wbyte  = '0;
            o_q_data.lanes[j].rconst = '0;
            o_q_data.lanes[j].dev    = 1'b0;
            o_q_data.lanes[j].flt    = 1'b0;
            if (is_rw && lane_valid[j]) begin
                o_q_data.lanes[j] = classify(lane_addr[j], is_read,
                                             i_write_data[8*j +: 8], i_overlay);
                if (is_read && i_overlay &&
                    (lane_addr[j][23:20] == omdec_pkg::REGION_ROM)) begin
                    touch = 1'b1;
                end
            end
        end
        if (i_mode == omdec_pkg::MODE_LOAD) begin
            o_q_data.lanes[0].tgt   = omdec_pkg::TGT_ROM;
            o_q_data.lanes[0].wr    = 1'b1;
            o_q_data.lanes[0].idx   = omdec_pkg::IDX_W'(i_address & ROM_MASK);
            o_q_data.lanes[0].wbyte = i_write_data[7:0];
        end
        o_q_data.normal_map = n_switched;
    end

    assign n_pending  = r_pending || touch;
    assign n_switched = is_read ? (r_switched || n_pending) : r_switched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 1'b0;
            r_switched <= 1'b0;
        end else if (accept) begin
            r_pending  <= n_pending;
            r_switched <= n_switched;
        end
    end

endmodule

[design/omdec_queue.sv]
module omdec_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  omdec_pkg::t_op i_data,
    output logic           o_full,
    input  logic           i_pop,
    output omdec_pkg::t_op o_data,
    output logic           o_empty
);

    localparam int PTR_W = $clog2(omdec_pkg::QDEPTH);
    localparam int CNT_W = $clog2(omdec_pkg::QDEPTH + 1);

    omdec_pkg::t_op   r_mem [omdec_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(omdec_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/omdec_back.sv]
`include "overlay_memory_map_decoder_core_defines.svh"

module omdec_back #(
    parameter int RAM_BYTES = omdec_pkg::RAM_BYTES_DEF,
    parameter int ROM_BYTES = omdec_pkg::ROM_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  omdec_pkg::t_op i_q_data,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [31:0]    o_read_data,
    output logic [3:0]     o_device_lanes,
    output logic [3:0]     o_fault_lanes,
    output logic           o_normal_map
);

    localparam int RAM_AW = $clog2(RAM_BYTES);
    localparam int ROM_AW = $clog2(ROM_BYTES);
    localparam int LANE_W = $clog2(omdec_pkg::LANES);
    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(omdec_pkg::LANES - 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [LANE_W-1:0]   r_cnt;
    omdec_pkg::t_op      r_op;
    logic                r_sel_valid;
    logic [LANE_W-1:0]   r_sel_lane;
    omdec_pkg::t_target  r_sel_tgt;
    logic                r_sel_wr;
    logic [7:0]          r_sel_const;
    logic [31:0]         r_rdata;
    logic [31:0]         n_rdata;
    logic                r_out_valid;
    logic [31:0]         r_out_rdata;
    logic [3:0]          r_out_dev;
    logic [3:0]          r_out_flt;
    logic                r_out_map;
    logic [7:0]          r_ram [RAM_BYTES];
    logic [7:0]          r_rom [ROM_BYTES];
    logic [7:0]          r_ram_q;
    logic [7:0]          r_rom_q;
    logic                start;
    logic                ram_we;
    logic                rom_we;
    logic [7:0]          cap_byte;
    logic [3:0]          dev_lanes;
    logic [3:0]          flt_lanes;
    omdec_pkg::t_lane_op cur;

    assign start   = (r_state == S_IDLE) && !i_q_empty && !r_out_valid;
    assign o_q_pop = start;
    assign cur     = r_op.lanes[r_cnt];
    assign ram_we  = (r_state == S_RUN) && (cur.tgt == omdec_pkg::TGT_RAM) && cur.wr;
    assign rom_we  = (r_state == S_RUN) && (cur.tgt == omdec_pkg::TGT_ROM) && cur.wr;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_cnt == LAST_LANE) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Byte stores: one lane per cycle, with registered read data.
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_ram[cur.idx[RAM_AW-1:0]] <= cur.wbyte;
        end
        r_ram_q <= r_ram[cur.idx[RAM_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (rom_we) begin
            r_rom[cur.idx[ROM_AW-1:0]] <= cur.wbyte;
        end
        r_rom_q <= r_rom[cur.idx[ROM_AW-1:0]];
    end

    always_comb begin
        if ((r_sel_tgt == omdec_pkg::TGT_RAM) && !r_sel_wr) begin
            cap_byte = r_ram_q;
        end else if ((r_sel_tgt == omdec_pkg::TGT_ROM) && !r_sel_wr) begin
            cap_byte = r_rom_q;
        end else begin
            cap_byte = r_sel_const;
        end
        n_rdata = r_rdata;
        if (r_sel_valid) begin
            n_rdata[8*r_sel_lane +: 8] = cap_byte;
        end
    end

    always_comb begin
        for (int j = 0; j < omdec_pkg::LANES; j++) begin
            dev_lanes[j] = r_op.lanes[j].dev;
            flt_lanes[j] = r_op.lanes[j].flt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_sel_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel_valid <= (r_state == S_RUN);
            if (start) begin
                r_cnt <= '0;
            end else if (r_state == S_RUN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_FLUSH) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op    <= i_q_data;
            r_rdata <= '0;
        end else begin
            r_rdata <= n_rdata;
        end
        r_sel_lane  <= r_cnt;
        r_sel_tgt   <= cur.tgt;
        r_sel_wr    <= cur.wr;
        r_sel_const <= cur.rconst;
        if (r_state == S_FLUSH) begin
            r_out_rdata <= n_rdata;
            r_out_dev   <= dev_lanes;
            r_out_flt   <= flt_lanes;
            r_out_map   <= r_op.normal_map;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_read_data    = r_out_rdata;
    assign o_device_lanes = r_out_dev;
    assign o_fault_lanes  = r_out_flt;
    assign o_normal_map   = r_out_map;

    `OMD_ASSERT_SAME(a_no_overwrite, r_state == S_FLUSH, !r_out_valid, "result word overwritten")
    `OMD_ASSERT_NEXT(a_run_ends, (r_state == S_RUN) && (r_cnt == LAST_LANE), r_state == S_FLUSH, "lane sweep did not end")
    `OMD_ASSERT_NEXT(a_capture, r_state == S_RUN, r_sel_valid, "lane capture missing")

endmodule

[design/overlay_memory_map_decoder_core.sv]
// Each word goes through a start step, four byte lanes one per cycle through single-port
// byte stores and a capture step, and then waits in the result register until it is taken;
// the sequencer takes no new word until then. The two-entry queue keeps taking words
// meanwhile while it has room.
// Reset (i_rst_n low, synchronous) clears the queue, the sequencer and the map bits;
// RAM and ROM contents are not cleared.
module overlay_memory_map_decoder_core #(
    parameter int RAM_BYTES = omdec_pkg::RAM_BYTES_DEF,
    parameter int ROM_BYTES = omdec_pkg::ROM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_access_size,
    input  logic [23:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic        i_overlay,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_read_data,
    output logic [3:0]  o_device_lanes,
    output logic [3:0]  o_fault_lanes,
    output logic        o_normal_map
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    omdec_pkg::t_op q_in;
    omdec_pkg::t_op q_out;

    assign full = q_full;

    omdec_front #(
        .RAM_BYTES (RAM_BYTES),
        .ROM_BYTES (ROM_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_q_full      (q_full),
        .i_mode        (i_mode),
        .i_access_size (i_access_size),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .i_overlay     (i_overlay),
        .o_q_push      (q_push),
        .o_q_data      (q_in)
    );

    omdec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    omdec_back #(
        .RAM_BYTES (RAM_BYTES),
        .ROM_BYTES (ROM_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_data       (q_out),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_read_data    (o_read_data),
        .o_device_lanes (o_device_lanes),
        .o_fault_lanes  (o_fault_lanes),
        .o_normal_map   (o_normal_map)
    );

endmodule

[tb/sv/overlay_memory_map_decoder_core_checker.sv]
module overlay_memory_map_decoder_core_checker #(
    parameter int RAM_BYTES = omdec_pkg::RAM_BYTES_DEF,
    parameter int ROM_BYTES = omdec_pkg::ROM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_access_size,
    input  logic [23:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic        i_overlay,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [31:0] i_read_data,
    input  logic [3:0]  i_device_lanes,
    input  logic [3:0]  i_fault_lanes,
    input  logic        i_normal_map,
    output int          o_fail_count,
    output int          o_pending
);
    import omdec_pkg::*;

    localparam logic [23:0] RAM_MASK = 24'(RAM_BYTES - 1);
    localparam logic [23:0] ROM_MASK = 24'(ROM_BYTES - 1);

    typedef struct packed {
        logic [31:0] read_data;
        logic [3:0]  device_lanes;
        logic [3:0]  fault_lanes;
        logic        normal_map;
    } t_bus_result;

    logic [7:0]  ram_bytes [RAM_BYTES];
    logic [7:0]  rom_bytes [ROM_BYTES];
    logic        switch_pending = 1'b0;
    logic        map_switched = 1'b0;
    t_bus_result awaited_results [$];
    int          mismatch_count = 0;

    // Decodes one bus word byte by byte, updating the stores and the map bits.
    function automatic t_bus_result decode_access(
        input logic [1:0]  mode,
        input logic [1:0]  size,
        input logic [23:0] addr,
        input logic [31:0] wdata,
        input logic        ovl
    );
        t_bus_result res;
        logic [23:0] a;
        logic [7:0]  rbyte;
        logic [7:0]  wbyte;
        logic        is_read;
        int          nbytes;
        int          lane;
        res = '0;
        is_read = (mode == MODE_READ);
        nbytes = (size == SIZE_BYTE) ? 1 : (size == SIZE_WORD) ? 2 : 4;
        if (mode == MODE_READ || mode == MODE_WRITE) begin
            for (int i = 0; i < nbytes; i++) begin
                // The sum wraps within 24 bits, as the bus does.
                a = addr + 24'(i);
                lane = nbytes - 1 - i;
                wbyte = wdata[8*lane +: 8];
                rbyte = 8'h00;
                case (a[23:20])
                    REGION_LOW_0, REGION_LOW_1, REGION_LOW_2, REGION_LOW_3: begin
                        if (is_read) begin
                            rbyte = ovl ? rom_bytes[a & ROM_MASK] : ram_bytes[a & RAM_MASK];
                        end else if (!ovl) begin
                            ram_bytes[a & RAM_MASK] = wbyte;
                        end
                    end
                    REGION_ROM: begin
                        if (is_read) begin
                            switch_pending |= ovl;
                            rbyte = rom_bytes[(a - ROM_BASE) & ROM_MASK];
                        end
                    end
                    REGION_MIRROR_A, REGION_MIRROR_B: begin
                        if (ovl && is_read) begin
                            rbyte = ram_bytes[(a - MIRROR_BASE) & RAM_MASK];
                        end else if (ovl) begin
                            ram_bytes[(a - MIRROR_BASE) & RAM_MASK] = wbyte;
                        end
                    end
                    REGION_IWM: begin
                        res.fault_lanes[lane] = 1'b1;
                        if (is_read)
                            rbyte = IWM_BYTE;
                    end
                    REGION_DEV: begin
                        if (a[VIA_SEL_BIT])
                            res.device_lanes[lane] = 1'b1;
                        else
                            res.fault_lanes[lane] = 1'b1;
                    end
                    default: res.fault_lanes[lane] = 1'b1;
                endcase
                res.read_data[8*lane +: 8] = rbyte;
            end
            if (is_read)
                map_switched |= switch_pending;
        end else if (mode == MODE_LOAD) begin
            rom_bytes[addr & ROM_MASK] = wdata[7:0];
        end
        res.normal_map = map_switched;
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            if (mismatch_count < 10)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_bus_result want;
        if (!i_rst_n) begin
            awaited_results.delete();
            switch_pending = 1'b0;
            map_switched = 1'b0;
        end else begin
            if (i_pop && !i_empty) begin
                if (awaited_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result word with nothing expected: data %h",
                                 $time, i_read_data);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("read_data", want.read_data, i_read_data);
                    compare_field("device_lanes", want.device_lanes, i_device_lanes);
                    compare_field("fault_lanes", want.fault_lanes, i_fault_lanes);
                    compare_field("normal_map", want.normal_map, i_normal_map);
                end
            end
            if (i_push && !i_full)
                awaited_results.push_back(decode_access(i_mode, i_access_size, i_address,
                                                        i_write_data, i_overlay));
        end
        o_fail_count <= mismatch_count;
        o_pending <= awaited_results.size();
    end

endmodule

[tb/sv/overlay_memory_map_decoder_core_test.sv]
module overlay_memory_map_decoder_core_test;
    import omdec_pkg::*;

    localparam int          RAM_BYTES = RAM_BYTES_DEF;
    localparam int          ROM_BYTES = ROM_BYTES_DEF;
    localparam logic [23:0] RAM_MASK = 24'(RAM_BYTES - 1);
    localparam logic [23:0] ROM_MASK = 24'(ROM_BYTES - 1);
    localparam logic [1:0]  MODE_NONE = 2'd3;
    localparam logic [1:0]  SIZE_LONG = 2'd2;
    localparam logic [1:0]  SIZE_ODD  = 2'd3;
    localparam int          WORDS_PER_PHASE = 375;
    localparam int          SWITCH_PHASE = 2;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  size;
        logic [23:0] addr;
        logic [31:0] data;
        logic        ovl;
    } t_bus_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_mode = MODE_READ;
    logic [1:0]  i_access_size = SIZE_BYTE;
    logic [23:0] i_address = '0;
    logic [31:0] i_write_data = '0;
    logic        i_overlay = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_read_data;
    logic [3:0]  o_device_lanes;
    logic [3:0]  o_fault_lanes;
    logic        o_normal_map;

    int fail_count;
    int pending_count;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int cycle_count = 0;
    int idle_by_phase [4] = '{0, 66, 0, 13};
    int stall_by_phase [4] = '{0, 0, 66, 13};

    // Store entries the stimulus has filled; reads are kept to these.
    bit ram_written [RAM_BYTES];
    bit rom_loaded [ROM_BYTES];

    overlay_memory_map_decoder_core #(
        .RAM_BYTES(RAM_BYTES),
        .ROM_BYTES(ROM_BYTES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_mode         (i_mode),
        .i_access_size  (i_access_size),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_overlay      (i_overlay),
        .empty          (empty),
        .pop            (pop),
        .o_read_data    (o_read_data),
        .o_device_lanes (o_device_lanes),
        .o_fault_lanes  (o_fault_lanes),
        .o_normal_map   (o_normal_map)
    );

    overlay_memory_map_decoder_core_checker #(
        .RAM_BYTES(RAM_BYTES),
        .ROM_BYTES(ROM_BYTES)
    ) bus_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_mode         (i_mode),
        .i_access_size  (i_access_size),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_overlay      (i_overlay),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_read_data    (o_read_data),
        .i_device_lanes (o_device_lanes),
        .i_fault_lanes  (o_fault_lanes),
        .i_normal_map   (o_normal_map),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("overlay_memory_map_decoder_core regression: fail");
            $finish;
        end
    end

    function automatic int byte_count(input logic [1:0] size);
        return (size == SIZE_BYTE) ? 1 : (size == SIZE_WORD) ? 2 : 4;
    endfunction

    // Finds the store entry, if any, that one byte address reaches under the given map.
    function automatic bit store_entry(input logic [23:0] a, input logic ovl,
                                       output bit is_rom, output int idx);
        is_rom = 1'b0;
        idx = 0;
        case (a[23:20])
            REGION_LOW_0, REGION_LOW_1, REGION_LOW_2, REGION_LOW_3: begin
                is_rom = ovl;
                idx = int'(a & (ovl ? ROM_MASK : RAM_MASK));
                return 1'b1;
            end
            REGION_ROM: begin
                is_rom = 1'b1;
                idx = int'((a - ROM_BASE) & ROM_MASK);
                return 1'b1;
            end
            REGION_MIRROR_A, REGION_MIRROR_B: begin
                idx = int'((a - MIRROR_BASE) & RAM_MASK);
                return ovl;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit read_is_defined(input t_bus_word w);
        bit is_rom;
        int idx;
        for (int i = 0; i < byte_count(w.size); i++) begin
            if (store_entry(w.addr + 24'(i), w.ovl, is_rom, idx)) begin
                if (is_rom ? !rom_loaded[idx] : !ram_written[idx])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [23:0] random_address();
        logic [23:0] a;
        a = 24'($urandom());
        // Most addresses fall into two small windows at the ends of the store index
        // range, so that reads soon find filled bytes and long accesses wrap across.
        if ($urandom_range(99) < 75)
            a[16:0] = {{12{a[16]}}, a[4:0]};
        return a;
    endfunction

    function automatic t_bus_word random_word(input bit allow_switch);
        t_bus_word   w;
        logic [23:0] last;
        int          pick;
        pick = $urandom_range(99);
        w.mode = (pick < 45) ? MODE_READ : (pick < 75) ? MODE_WRITE :
                 (pick < 93) ? MODE_LOAD : MODE_NONE;
        w.size = ($urandom_range(9) == 0) ? SIZE_ODD : 2'($urandom_range(2));
        w.data = $urandom();
        for (int tries = 0; tries < 8; tries++) begin
            w.addr = random_address();
            w.ovl = 1'($urandom_range(1));
            if (w.mode != MODE_READ)
                return w;
            // The map bit is sticky, so early phases keep overlay reads out of the ROM region.
            last = w.addr + 24'd3;
            if (!allow_switch && (w.addr[23:20] == REGION_ROM || last[23:20] == REGION_ROM))
                w.ovl = 1'b0;
            if (read_is_defined(w))
                return w;
        end
        // No safe read was found, so the word becomes a write, which fills any RAM bytes it reaches.
        w.mode = MODE_WRITE;
        return w;
    endfunction

    task automatic issue(input t_bus_word w);
        bit is_rom;
        int idx;
        if (w.mode == MODE_LOAD) begin
            rom_loaded[w.addr & ROM_MASK] = 1'b1;
        end else if (w.mode == MODE_WRITE) begin
            for (int i = 0; i < byte_count(w.size); i++) begin
                if (store_entry(w.addr + 24'(i), w.ovl, is_rom, idx)) begin
                    if (!is_rom)
                        ram_written[idx] = 1'b1;
                end
            end
        end
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_mode <= w.mode;
        i_access_size <= w.size;
        i_address <= w.addr;
        i_write_data <= w.data;
        i_overlay <= w.ovl;
        do @(posedge i_clk); while (full);
    endtask

    initial begin
        bit allow_switch;
        allow_switch = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ROM bytes at both ends of the index range; only the low data byte counts.
        issue(t_bus_word'{MODE_LOAD, SIZE_BYTE, 24'h000000, 32'hffffff5a, 1'b0});
        issue(t_bus_word'{MODE_LOAD, SIZE_LONG, 24'h000001, 32'h000000a5, 1'b1});
        issue(t_bus_word'{MODE_LOAD, SIZE_BYTE, 24'h400002, 32'h12345600, 1'b0});
        issue(t_bus_word'{MODE_LOAD, SIZE_BYTE, 24'h3f0003, 32'h00000077, 1'b0});
        issue(t_bus_word'{MODE_LOAD, SIZE_BYTE, 24'hffffff, 32'hdeadbeef, 1'b1});
        // Writes: low RAM, a long write that wraps past the top of the space,
        // the mirror under overlay, and writes that must be dropped.
        issue(t_bus_word'{MODE_WRITE, SIZE_LONG, 24'h000000, 32'h01234567, 1'b0});
        issue(t_bus_word'{MODE_WRITE, SIZE_LONG, 24'hffffff, 32'h89abcdef, 1'b0});
        issue(t_bus_word'{MODE_WRITE, SIZE_WORD, 24'h61fffe, 32'hffffffff, 1'b1});
        issue(t_bus_word'{MODE_WRITE, SIZE_BYTE, 24'h000010, 32'h000000ff, 1'b1});
        issue(t_bus_word'{MODE_WRITE, SIZE_LONG, 24'h400000, 32'hffffffff, 1'b1});
        issue(t_bus_word'{MODE_WRITE, SIZE_LONG, 24'heffffe, 32'h5555aaaa, 1'b0});
        // Reads across every region and both maps.
        issue(t_bus_word'{MODE_READ, SIZE_LONG, 24'h000000, 32'h00000000, 1'b0});
        issue(t_bus_word'{MODE_READ, SIZE_LONG, 24'hffffff, 32'hffffffff, 1'b0});
        issue(t_bus_word'{MODE_READ, SIZE_WORD, 24'h7ffffe, 32'h00000000, 1'b1});
        issue(t_bus_word'{MODE_READ, SIZE_LONG, 24'h600000, 32'h00000000, 1'b0});
        issue(t_bus_word'{MODE_READ, SIZE_LONG, 24'h000000, 32'h00000000, 1'b1});
        issue(t_bus_word'{MODE_READ, SIZE_LONG, 24'h40ffff, 32'h00000000, 1'b0});
        issue(t_bus_word'{MODE_READ, SIZE_LONG, 24'hd00000, 32'h00000000, 1'b0});
        issue(t_bus_word'{MODE_READ, SIZE_LONG, 24'he7fffe, 32'h00000000, 1'b0});
        issue(t_bus_word'{MODE_READ, SIZE_LONG, 24'h5ffffe, 32'h00000000, 1'b0});
        issue(t_bus_word'{MODE_READ, SIZE_LONG, 24'h8ffffe, 32'h00000000, 1'b1});
        issue(t_bus_word'{MODE_READ, SIZE_LONG, 24'haffffe, 32'h00000000, 1'b0});
        issue(t_bus_word'{MODE_READ, SIZE_BYTE, 24'hcfffff, 32'h00000000, 1'b0});
        // The unused mode and the odd size code.
        issue(t_bus_word'{MODE_NONE, SIZE_LONG, 24'he80000, 32'hffffffff, 1'b1});
        issue(t_bus_word'{MODE_READ, SIZE_ODD, 24'h000000, 32'h00000000, 1'b0});
        issue(t_bus_word'{MODE_WRITE, SIZE_ODD, 24'h1ffffc, 32'h0f0f0f0f, 1'b0});

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = idle_by_phase[phase];
            pop_stall_pct = stall_by_phase[phase];
            if (phase == SWITCH_PHASE) begin
                // A read of ROM at its high address under overlay sets the map bit.
                issue(t_bus_word'{MODE_READ, SIZE_WORD, 24'h400000, 32'h00000000, 1'b1});
                allow_switch = 1'b1;
            end
            repeat (WORDS_PER_PHASE) issue(random_word(allow_switch));
        end
        push <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("overlay_memory_map_decoder_core regression: pass");
        else
            $display("overlay_memory_map_decoder_core regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/omdec_pkg.sv
design/omdec_front.sv
design/omdec_queue.sv
design/omdec_back.sv
design/overlay_memory_map_decoder_core.sv
tb/sv/overlay_memory_map_decoder_core_checker.sv
tb/sv/overlay_memory_map_decoder_core_test.sv
